// ===== design/accel_tilt_angles_top_macros.svh =====
// assertion macros shared by the tilt angle checker
// each macro expects clk and arst_n in the scope where it is used
`ifndef ACCEL_TILT_ANGLES_TOP_MACROS_SVH
`define ACCEL_TILT_ANGLES_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ATL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ATL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/atl_pkg.sv =====
// shared types and constants for the accelerometer tilt angle pipeline
// no dependencies
`timescale 1ns / 1ps

package atl_pkg;

	localparam int SMP_W     = 16;               // raw sample width
	localparam int ANG_W     = 16;               // output angle width
	localparam int SQ_W      = 31;               // one square, unsigned
	localparam int SUM_W     = 32;               // sum of two squares
	localparam int FRAC_SH   = 16;               // radicand scaling, 8 fraction bits of root
	localparam int RAD_W     = SUM_W + FRAC_SH;  // radicand width
	localparam int ROOT_W    = RAD_W / 2;        // root width
	localparam int REM_W     = ROOT_W + 2;       // partial remainder width
	localparam int SQRT_CELLS = ROOT_W;          // one root bit per cell
	localparam int XW        = 27;               // cordic x and y width
	localparam int ZW        = 24;               // cordic angle accumulator width
	localparam int NUM_SH    = 8;                // numerator fraction bits
	localparam int TABLE_LEN = 24;

	localparam logic signed [ANG_W-1:0] QUARTER_TURN = 16'sd23040;
	localparam logic signed [ZW:0]      QT_WIDE      = 25'sd23040;
	localparam logic signed [ZW:0]      ROUND_BIAS   = 25'sd128;

	// atan(2^-i) in degrees * 65536
	localparam logic signed [ZW-1:0] ATAN_TABLE [TABLE_LEN] = '{
		24'sd2949120, 24'sd1740967, 24'sd919879, 24'sd466945,
		24'sd234379,  24'sd117304,  24'sd58666,  24'sd29335,
		24'sd14668,   24'sd7334,    24'sd3667,   24'sd1833,
		24'sd917,     24'sd458,     24'sd229,    24'sd115,
		24'sd57,      24'sd29,      24'sd14,     24'sd7,
		24'sd4,       24'sd2,       24'sd1,      24'sd0
	};

	typedef struct packed {
		logic [RAD_W-1:0]        rad;
		logic [REM_W-1:0]        rem;
		logic [ROOT_W-1:0]       root;
		logic signed [SMP_W-1:0] num;
		logic                    mag_zero;
	} sqrt_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 mag_zero;
		logic                 num_zero;
		logic                 num_neg;
	} cordic_t;

endpackage

// ===== design/accel_tilt_angles_top.sv =====
// accelerometer tilt angles, top level; depends on atl_pkg and atl_lane
// sample channel: sample_valid / sample_stall with accel_x, accel_y, accel_z
// result channel: tilt_valid / tilt_stall with tilt_x, tilt_y (degrees * 256)
// tilt_x = atan2(y, |x,z|), tilt_y = -atan2(x, |y,z|), both within +-23040
// two identical lanes run side by side, each a row of cells: squares, sum,
// 24 square root cells (one root bit each), CORDIC_STAGES cordic cells, rounding
// a sample transfer sets the first valid bit, which runs down vld_q cell by cell
// and then into the output register that drives tilt_valid
// throughput: one sample per cycle while the receiver takes results;
// the cell rows advance in lock step, one cell per cycle
// a finished result sits in the output register; while it is stalled the rows
// keep moving as long as the last cell is empty, so samples still transfer
// sample_stall rises only when the output register is stalled and the last
// cell holds a result, then the whole row freezes with its contents intact
// reset clears the stage valid bits and the output valid, data is not reset
`timescale 1ns / 1ps

module accel_tilt_angles_top import atl_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sample_valid,
	output logic                    sample_stall,
	input  logic signed [SMP_W-1:0] accel_x,
	input  logic signed [SMP_W-1:0] accel_y,
	input  logic signed [SMP_W-1:0] accel_z,
	output logic                    tilt_valid,
	input  logic                    tilt_stall,
	output logic signed [ANG_W-1:0] tilt_x,
	output logic signed [ANG_W-1:0] tilt_y
);

	// squares, sum, root cells, cordic cells, rounding
	localparam int LAT = 2 + SQRT_CELLS + CORDIC_STAGES + 1;

	logic [LAT-1:0]          vld_q;      // one valid bit per cell position
	logic                    out_load;   // output register may take a new value
	logic                    adv;        // all cells move one step
	logic                    tilt_valid_q;
	logic signed [ANG_W-1:0] tilt_x_q;
	logic signed [ANG_W-1:0] tilt_y_q;
	logic signed [ANG_W-1:0] ang_x;
	logic signed [ANG_W-1:0] ang_y;

	// output register is free when empty or drained this cycle
	assign out_load     = !tilt_valid_q || !tilt_stall;
	// freeze only when the last cell has a result that cannot leave
	assign adv          = out_load || !vld_q[LAT-1];
	assign sample_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], sample_valid};
		end
	end

	// x tilt: numerator y over magnitude of x and z
	atl_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_lane_x (
		.clk    (clk),
		.en     (adv),
		.num    (accel_y),
		.side_a (accel_x),
		.side_b (accel_z),
		.angle  (ang_x)
	);

	// y tilt: numerator x over magnitude of y and z, negated below
	atl_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_lane_y (
		.clk    (clk),
		.en     (adv),
		.num    (accel_x),
		.side_a (accel_y),
		.side_b (accel_z),
		.angle  (ang_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_valid_q <= 1'b0;
		end else if (out_load) begin
			tilt_valid_q <= vld_q[LAT-1];
		end
	end

	// result payload, held while the receiver stalls
	always_ff @(posedge clk) begin
		if (out_load && vld_q[LAT-1]) begin
			tilt_x_q <= ang_x;
			tilt_y_q <= -ang_y;
		end
	end

	assign tilt_valid = tilt_valid_q;
	assign tilt_x     = tilt_x_q;
	assign tilt_y     = tilt_y_q;

endmodule

// ===== design/atl_sqrt_cell.sv =====
// one restoring square root cell: settles one root bit and registers it
// depends on atl_pkg
`timescale 1ns / 1ps

module atl_sqrt_cell import atl_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  sqrt_t d,
	output sqrt_t q
);

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	sqrt_t            nxt;

	always_comb begin
		nxt    = d;
		rem_sh = {d.rem[REM_W-3:0], d.rad[RAD_W-1 -: 2]};
		trial  = {d.root, 2'b01};
		nxt.rad = {d.rad[RAD_W-3:0], 2'b00};
		if (rem_sh >= trial) begin
			nxt.rem  = rem_sh - trial;
			nxt.root = {d.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = rem_sh;
			nxt.root = {d.root[ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

// ===== design/atl_cordic_cell.sv =====
// one cordic vectoring cell with a fixed shift, rotates toward y = 0
// depends on atl_pkg
`timescale 1ns / 1ps

module atl_cordic_cell import atl_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic    clk,
	input  logic    en,
	input  cordic_t d,
	output cordic_t q
);

	logic signed [XW-1:0] y_sh;
	logic signed [XW-1:0] x_sh;
	cordic_t              nxt;

	always_comb begin
		nxt  = d;
		y_sh = $signed(d.y) >>> STAGE;
		x_sh = $signed(d.x) >>> STAGE;
		if (!d.y[XW-1]) begin
			nxt.x = d.x + y_sh;
			nxt.y = d.y - x_sh;
			nxt.z = d.z + ATAN_TABLE[STAGE];
		end else begin
			nxt.x = d.x - y_sh;
			nxt.y = d.y + x_sh;
			nxt.z = d.z - ATAN_TABLE[STAGE];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

// ===== design/atl_lane.sv =====
// one angle lane: squares, sum, square root cell chain, cordic cell chain, rounding
// depends on atl_pkg, atl_sqrt_cell and atl_cordic_cell
`timescale 1ns / 1ps

module atl_lane import atl_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [SMP_W-1:0] num,
	input  logic signed [SMP_W-1:0] side_a,
	input  logic signed [SMP_W-1:0] side_b,
	output logic signed [ANG_W-1:0] angle
);

	logic signed [2*SMP_W-1:0] prod_a;
	logic signed [2*SMP_W-1:0] prod_b;
	logic [SQ_W-1:0]           sq_a_s1;
	logic [SQ_W-1:0]           sq_b_s1;
	logic signed [SMP_W-1:0]   num_s1;
	logic [SUM_W-1:0]          sum_nxt;
	logic [SUM_W-1:0]          sum_s2;
	logic signed [SMP_W-1:0]   num_s2;
	logic                      zero_s2;

	sqrt_t   sq  [SQRT_CELLS+1];
	cordic_t crd [CORDIC_STAGES+1];

	logic signed [ZW:0]      z_round;
	logic signed [ZW:0]      z_shift;
	logic signed [ANG_W-1:0] angle_nxt;
	logic signed [ANG_W-1:0] angle_q;

	// squares of the two magnitude components
	assign prod_a = side_a * side_a;
	assign prod_b = side_b * side_b;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_a_s1 <= prod_a[SQ_W-1:0];
			sq_b_s1 <= prod_b[SQ_W-1:0];
			num_s1  <= num;
		end
	end

	assign sum_nxt = {1'b0, sq_a_s1} + {1'b0, sq_b_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2  <= sum_nxt;
			num_s2  <= num_s1;
			zero_s2 <= (sum_nxt == '0);
		end
	end

	// square root of sum * 2^16, one root bit per cell
	always_comb begin
		sq[0].rad      = {sum_s2, {FRAC_SH{1'b0}}};
		sq[0].rem      = '0;
		sq[0].root     = '0;
		sq[0].num      = num_s2;
		sq[0].mag_zero = zero_s2;
	end

	for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
		atl_sqrt_cell u_cell (
			.clk (clk),
			.en  (en),
			.d   (sq[i]),
			.q   (sq[i+1])
		);
	end

	// vectoring start: x = magnitude, y = numerator with 8 fraction bits
	always_comb begin
		crd[0].x        = {{(XW-ROOT_W){1'b0}}, sq[SQRT_CELLS].root};
		crd[0].y        = {{(XW-SMP_W-NUM_SH){sq[SQRT_CELLS].num[SMP_W-1]}},
			sq[SQRT_CELLS].num, {NUM_SH{1'b0}}};
		crd[0].z        = '0;
		crd[0].mag_zero = sq[SQRT_CELLS].mag_zero;
		crd[0].num_zero = (sq[SQRT_CELLS].num == '0);
		crd[0].num_neg  = sq[SQRT_CELLS].num[SMP_W-1];
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		atl_cordic_cell #(.STAGE(i)) u_cell (
			.clk (clk),
			.en  (en),
			.d   (crd[i]),
			.q   (crd[i+1])
		);
	end

	// round to 1/256 degree and saturate at a quarter turn
	assign z_round = $signed({crd[CORDIC_STAGES].z[ZW-1], crd[CORDIC_STAGES].z}) + ROUND_BIAS;
	assign z_shift = z_round >>> NUM_SH;

	always_comb begin
		if (crd[CORDIC_STAGES].mag_zero) begin
			if (crd[CORDIC_STAGES].num_zero) begin
				angle_nxt = '0;
			end else if (crd[CORDIC_STAGES].num_neg) begin
				angle_nxt = -QUARTER_TURN;
			end else begin
				angle_nxt = QUARTER_TURN;
			end
		end else if (z_shift > QT_WIDE) begin
			angle_nxt = QUARTER_TURN;
		end else if (z_shift < -QT_WIDE) begin
			angle_nxt = -QUARTER_TURN;
		end else begin
			angle_nxt = z_shift[ANG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= angle_nxt;
		end
	end

	assign angle = angle_q;

endmodule

// ===== design/atl_checker.sv =====
// port level checks for the tilt angle block, bound to its top level
// depends on atl_pkg and accel_tilt_angles_top_macros.svh
`timescale 1ns / 1ps

`include "accel_tilt_angles_top_macros.svh"

module atl_checker import atl_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    sample_stall,
	input logic                    tilt_valid,
	input logic                    tilt_stall,
	input logic signed [ANG_W-1:0] tilt_x,
	input logic signed [ANG_W-1:0] tilt_y
);

	// a stalled result transfer keeps its payload
	`ATL_ASSERT_NEXT(a_hold, tilt_valid && tilt_stall, tilt_valid && $stable(tilt_x) && $stable(tilt_y), "stalled result changed")

	// back pressure only comes from a stalled result
	`ATL_ASSERT_NOW(a_stall_src, sample_stall, tilt_valid && tilt_stall, "sample stall without a stalled result")

	// angles never pass a quarter turn
	`ATL_ASSERT_NOW(a_range_x, tilt_valid, tilt_x <= QUARTER_TURN && tilt_x >= -QUARTER_TURN, "tilt_x out of range")

	`ATL_ASSERT_NOW(a_range_y, tilt_valid, tilt_y <= QUARTER_TURN && tilt_y >= -QUARTER_TURN, "tilt_y out of range")

endmodule

bind accel_tilt_angles_top atl_checker u_atl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_stall (sample_stall),
	.tilt_valid   (tilt_valid),
	.tilt_stall   (tilt_stall),
	.tilt_x       (tilt_x),
	.tilt_y       (tilt_y)
);

// ===== tb/accel_tilt_angles_top_tb.sv =====
// self-checking testbench for accel_tilt_angles_top: directed rows, then random sample triples
// carries its own cordic tilt angle predictor; depends on atl_pkg for widths only
`timescale 1ns / 1ps

module accel_tilt_angles_top_tb;
	import atl_pkg::*;

	localparam int CORDIC_STAGES  = 16;
	localparam int PIPE_LATENCY   = CORDIC_STAGES + 28;  // sample transfer to result transfer
	localparam int RANDOM_ITEMS   = 650;
	localparam int WATCHDOG_LIMIT = 2000;                // cycles with no transfer at all
	localparam int RIGHT_ANGLE    = 23040;               // 90 degrees in 1/256 degree
	localparam int ANGLE_STEPS    = 24;

	// atan(2^-i) in degrees * 65536, kept apart from the design's copy
	localparam longint ATAN_STEP [ANGLE_STEPS] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef struct packed {
		logic signed [SMP_W-1:0] x;
		logic signed [SMP_W-1:0] y;
		logic signed [SMP_W-1:0] z;
	} sample_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] tx;
		logic signed [ANG_W-1:0] ty;
	} tilt_pair_t;

	// one directed row: sample, which angles are typed in, and the typed angles
	typedef struct packed {
		logic signed [SMP_W-1:0] x;
		logic signed [SMP_W-1:0] y;
		logic signed [SMP_W-1:0] z;
		logic                    tx_known;
		logic                    ty_known;
		logic signed [ANG_W-1:0] tx;
		logic signed [ANG_W-1:0] ty;
	} directed_row_t;

	localparam int DIRECTED_COUNT = 23;
	localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{0, 0, 0, 1, 1, 0, 0},                  // no acceleration at all
		'{0, 32767, 0, 1, 0, 23040, 0},          // pure +y, x tilt pinned at +90
		'{0, -32768, 0, 1, 0, -23040, 0},        // pure -y, x tilt pinned at -90
		'{32767, 0, 0, 0, 1, 0, -23040},         // pure +x, y tilt pinned at -90
		'{-32768, 0, 0, 0, 1, 0, 23040},         // pure -x, y tilt pinned at +90
		'{0, 1, 0, 1, 0, 23040, 0},              // smallest numerator, zero magnitude
		'{-1, 0, 0, 0, 1, 0, 23040},
		'{0, 0, 32767, 0, 0, 0, 0},              // flat, zero numerators
		'{0, 0, -32768, 0, 0, 0, 0},
		'{32767, 32767, 32767, 0, 0, 0, 0},      // all axes at the extremes
		'{-32768, -32768, -32768, 0, 0, 0, 0},
		'{-32768, 32767, 0, 0, 0, 0, 0},
		'{32767, -32768, -32768, 0, 0, 0, 0},
		'{1, 1, 1, 0, 0, 0, 0},                  // tiny magnitudes
		'{-1, -1, -1, 0, 0, 0, 0},
		'{1, 0, -32768, 0, 0, 0, 0},             // tiny numerator, huge magnitude
		'{0, 32767, 1, 0, 0, 0, 0},              // just short of the clamp
		'{0, -32768, 1, 0, 0, 0, 0},
		'{32767, 0, 1, 0, 0, 0, 0},
		'{16384, 0, 0, 0, 1, 0, -23040},         // one g on x
		'{0, 16384, -16384, 0, 0, 0, 0},
		'{-32768, -32768, 0, 0, 0, 0, 0},        // exact 45 degree case
		'{12345, -6789, 1000, 0, 0, 0, 0}
	};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    sample_valid = 1'b0;
	logic                    sample_stall;
	logic signed [SMP_W-1:0] accel_x = '0;
	logic signed [SMP_W-1:0] accel_y = '0;
	logic signed [SMP_W-1:0] accel_z = '0;
	logic                    tilt_valid;
	logic                    tilt_stall = 1'b0;
	logic signed [ANG_W-1:0] tilt_x;
	logic signed [ANG_W-1:0] tilt_y;

	tilt_pair_t pending_tilts [$];  // expected angles, oldest first
	int         mismatches = 0;
	int         idle_cycles = 0;
	bit         draining = 1'b0;   // receiver stops stalling near the end

	accel_tilt_angles_top #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.tilt_valid  (tilt_valid),
		.tilt_stall  (tilt_stall),
		.tilt_x      (tilt_x),
		.tilt_y      (tilt_y)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// bitwise integer square root, floor
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root = 0;
		longint unsigned probe = 64'd1 << 62;
		while (probe > v)
			probe >>= 2;
		while (probe != 0) begin
			if (v >= root + probe) begin
				v    -= root + probe;
				root  = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	// atan2(num, |a,b|) in 1/256 degree, by cordic vectoring, clamped to +-90
	function automatic logic signed [ANG_W-1:0] tilt_angle(input longint num, input longint a,
			input longint b);
		longint unsigned sq_sum;
		longint          vx, vy, acc, dx, dy, angle;
		sq_sum = longint'(a * a + b * b);
		if (sq_sum == 0) begin
			// zero magnitude: the sign of the numerator decides, zero stays zero
			if (num > 0)
				angle = RIGHT_ANGLE;
			else if (num < 0)
				angle = -RIGHT_ANGLE;
			else
				angle = 0;
		end else begin
			vx  = longint'(int_sqrt(sq_sum << 16));  // magnitude, 8 fraction bits
			vy  = num * 256;
			acc = 0;
			for (int i = 0; i < CORDIC_STAGES && i < ANGLE_STEPS; i++) begin
				dx = vy >>> i;
				dy = vx >>> i;
				if (vy >= 0) begin
					vx  += dx;
					vy  -= dy;
					acc += ATAN_STEP[i];
				end else begin
					vx  -= dx;
					vy  += dy;
					acc -= ATAN_STEP[i];
				end
			end
			angle = (acc + 128) >>> 8;
			if (angle > RIGHT_ANGLE)
				angle = RIGHT_ANGLE;
			if (angle < -RIGHT_ANGLE)
				angle = -RIGHT_ANGLE;
		end
		return angle[ANG_W-1:0];
	endfunction

	function automatic tilt_pair_t tilts_from_sample(input sample_t s);
		tilt_pair_t p;
		p.tx = tilt_angle(s.y, s.x, s.z);
		p.ty = -tilt_angle(s.x, s.y, s.z);
		return p;
	endfunction

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	// one axis value: mostly full range, with a bias toward edges, small values and +-16384
	function automatic logic signed [SMP_W-1:0] random_axis();
		int unsigned pick;
		pick = $urandom_range(0, 19);
		case (pick)
			0: return '0;
			1: return 16'sh7fff;
			2: return 16'sh8000;
			3, 4: return SMP_W'($urandom_range(0, 32)) - 16'sd16;
			5, 6: return SMP_W'(($urandom_range(0, 1) ? 16384 : -16384) +
					$urandom_range(0, 2000) - 1000);
			default: return SMP_W'($urandom);
		endcase
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		s.x = random_axis();
		s.y = random_axis();
		s.z = random_axis();
		// now and then leave one axis alone, so the zero-magnitude cases come up
		case ($urandom_range(0, 24))
			0: begin s.x = '0; s.z = '0; end
			1: begin s.y = '0; s.z = '0; end
			2: begin s.x = '0; s.y = '0; end
			default: ;
		endcase
		return s;
	endfunction

	// called at a falling edge; holds the sample until its transfer, returns at
	// the next falling edge with valid still high
	task automatic send_sample(input sample_t s, input tilt_pair_t want);
		sample_valid <= 1'b1;
		accel_x      <= s.x;
		accel_y      <= s.y;
		accel_z      <= s.z;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		pending_tilts.push_back(want);
		@(negedge clk);
	endtask

	initial begin
		sample_t    s;
		tilt_pair_t want;
		int         burst, gap, sent;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed rows back to back; typed angles override the predictor
		for (int r = 0; r < DIRECTED_COUNT; r++) begin
			s    = '{DIRECTED_ROWS[r].x, DIRECTED_ROWS[r].y, DIRECTED_ROWS[r].z};
			want = tilts_from_sample(s);
			if (DIRECTED_ROWS[r].tx_known)
				want.tx = DIRECTED_ROWS[r].tx;
			if (DIRECTED_ROWS[r].ty_known)
				want.ty = DIRECTED_ROWS[r].ty;
			send_sample(s, want);
		end

		// random samples in bursts; a gap of zero merges two bursts
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
				s = random_sample();
				send_sample(s, tilts_from_sample(s));
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		sample_valid <= 1'b0;

		// let every expected result arrive, then watch for strays
		draining = 1'b1;
		while (pending_tilts.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 16) @(posedge clk);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// receiver stall: phases of random length, each with a pattern of its own
	// (none, light random, heavy random, periodic)
	// ------------------------------------------------------------------
	int stall_mode = 0;
	int stall_left = 0;
	int stall_beat = 0;
	int stall_period = 2;

	always @(negedge clk) begin
		if (draining) begin
			tilt_stall <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode   = $urandom_range(0, 3);
				stall_left   = $urandom_range(20, 200);
				stall_period = $urandom_range(2, 7);
				stall_beat   = 0;
			end
			stall_left--;
			stall_beat++;
			case (stall_mode)
				0: tilt_stall <= 1'b0;
				1: tilt_stall <= ($urandom_range(0, 3) == 0);
				2: tilt_stall <= ($urandom_range(0, 3) != 0);
				default: tilt_stall <= ((stall_beat % stall_period) < (stall_period / 2));
			endcase
		end
	end

	// ------------------------------------------------------------------
	// result check: every result transfer against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_tilts
		tilt_pair_t want;
		if (arst_n && tilt_valid && !tilt_stall) begin
			if (pending_tilts.size() == 0) begin
				$display("%0t: unexpected result tilt_x=%0d tilt_y=%0d", $time, tilt_x, tilt_y);
				mismatches++;
			end else begin
				want = pending_tilts.pop_front();
				if (tilt_x !== want.tx) begin
					$display("%0t: tilt_x expected %0d got %0d", $time, want.tx, tilt_x);
					mismatches++;
				end
				if (tilt_y !== want.ty) begin
					$display("%0t: tilt_y expected %0d got %0d", $time, want.ty, tilt_y);
					mismatches++;
				end
			end
		end
	end

	// watchdog: a stuck handshake on either side ends the run
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (tilt_valid && !tilt_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
				idle_cycles, pending_tilts.size());
			$display("FAIL");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
+incdir+design
design/atl_pkg.sv
design/atl_sqrt_cell.sv
design/atl_cordic_cell.sv
design/atl_lane.sv
design/accel_tilt_angles_top.sv
design/atl_checker.sv
tb/accel_tilt_angles_top_tb.sv
